// ===== hw/rtl/tbrf_pkg.sv =====
`default_nettype none

package tbrf_pkg;

  // Fixed field widths of the channels
  localparam int unsigned OpWidth      = 2;
  localparam int unsigned PayloadWidth = 64;
  localparam int unsigned StatusWidth  = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ_A = 2'd1,
    OP_READ_B = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 2'd0,
    ST_CLOSED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Decision for one transaction, from the pointer logic to the datapath
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
    logic    closed;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbrf_in_if.sv =====
`default_nettype none

interface tbrf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [tbrf_pkg::OpWidth-1:0]           opcode;
  logic [tbrf_pkg::PayloadWidth-1:0]      payload;

  modport source (output valid, opcode, payload, input ready);
  modport sink   (input valid, opcode, payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tbrf_out_if.sv =====
`default_nettype none

interface tbrf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tbrf_pkg::StatusWidth-1:0]       status;
  logic [tbrf_pkg::PayloadWidth-1:0]      read_data;
  logic                                   closed_flag;

  modport source (output valid, status, read_data, closed_flag, input ready);
  modport sink   (input valid, status, read_data, closed_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tbrf_mem.sv =====
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module tbrf_mem #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [DATA_WIDTH-1:0]         wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic      [DATA_WIDTH-1:0]         rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbrf_ctrl.sv =====
`default_nettype none

// Write and reader counts (modulo 2*DEPTH), closed flag, per-op decision.
module tbrf_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             take,
  input  wire tbrf_pkg::op_t                    opcode,
  output tbrf_pkg::ctrl_t                       ctrl,
  output logic      [$clog2(DEPTH)-1:0]         wr_addr,
  output logic      [$clog2(DEPTH)-1:0]         rd_addr
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(2 * DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] WrapC  = CW'(2 * DEPTH - 1);

  logic [CW-1:0] wcnt, wcnt_next;
  logic [CW-1:0] acnt, acnt_next;
  logic [CW-1:0] bcnt, bcnt_next;
  logic          closed, closed_next;
  logic [CW-1:0] unseen_a, unseen_b, occ;

  function automatic logic [CW-1:0] unseen(input logic [CW-1:0] w, input logic [CW-1:0] r);
    logic [CW:0] sum;
    sum = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      sum = {1'b0, w} + (CW + 1)'(2 * DEPTH) - {1'b0, r};
    end
    return sum[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] advance(input logic [CW-1:0] c);
    return (c == WrapC) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = (c >= DepthC) ? c - DepthC : c;
    return s[AW-1:0];
  endfunction

  assign unseen_a = unseen(wcnt, acnt);
  assign unseen_b = unseen(wcnt, bcnt);
  assign occ      = (unseen_a > unseen_b) ? unseen_a : unseen_b;
  assign wr_addr  = slot(wcnt);

  always_comb begin
    wcnt_next   = wcnt;
    acnt_next   = acnt;
    bcnt_next   = bcnt;
    closed_next = closed;
    ctrl.wr_en  = 1'b0;
    ctrl.rd_en  = 1'b0;
    ctrl.status = tbrf_pkg::ST_OK;
    rd_addr     = slot(acnt);
    case (opcode)
      tbrf_pkg::OP_WRITE: begin
        if (closed) begin
          ctrl.status = tbrf_pkg::ST_CLOSED;
        end else if (occ >= DepthC) begin
          ctrl.status = tbrf_pkg::ST_FULL;
        end else begin
          ctrl.wr_en = take;
          wcnt_next  = advance(wcnt);
        end
      end
      tbrf_pkg::OP_READ_A: begin
        if (unseen_a == '0) begin
          ctrl.status = tbrf_pkg::ST_EMPTY;
        end else begin
          ctrl.rd_en = take;
          acnt_next  = advance(acnt);
        end
      end
      tbrf_pkg::OP_READ_B: begin
        rd_addr = slot(bcnt);
        if (unseen_b == '0) begin
          ctrl.status = tbrf_pkg::ST_EMPTY;
        end else begin
          ctrl.rd_en = take;
          bcnt_next  = advance(bcnt);
        end
      end
      tbrf_pkg::OP_CLOSE: begin
        if (unseen_a == '0 && unseen_b == '0) begin
          closed_next = 1'b1;
        end
      end
      default: begin
        ctrl.status = tbrf_pkg::ST_OK;
      end
    endcase
    ctrl.closed = closed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt   <= '0;
      acnt   <= '0;
      bcnt   <= '0;
      closed <= 1'b0;
    end else if (take) begin
      wcnt   <= wcnt_next;
      acnt   <= acnt_next;
      bcnt   <= bcnt_next;
      closed <= closed_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_reader_broadcast_fifo_core.sv =====
`default_nettype none

// Bounded FIFO read once by each of two readers (A and B).
// req channel: one transaction per operation (opcode + payload):
//   write, read for A, read for B, close.
// rsp channel: exactly one transaction per req transaction, in order,
//   carrying status, read_data (zero unless a read succeeded) and the
//   closed flag as it stands after the operation.
// Path: a result reaches rsp through the read stage (which waits on the entry
//   store's registered read) and then through the output register.
// Throughput: one operation per cycle while rsp is not held off; counts and
//   flag update at accept, so the next operation sees them at once.
// Reset (rst, synchronous): req.ready low, counts to zero, buffer open,
//   both stages empty. Store contents are not cleared; only written
//   entries are ever read.
// Stall: when rsp is held off, the result stays in the output register,
//   one more result waits in the read stage (store data held in place),
//   and req.ready drops until the output register drains.
module two_reader_broadcast_fifo_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  tbrf_in_if.sink   req,
  tbrf_out_if.source rsp
);

  localparam int unsigned AW = $clog2(DEPTH);

  tbrf_pkg::ctrl_t        ctrl;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic                   take;
  logic                   s1_adv;

  // read stage
  logic                   s1_valid;
  tbrf_pkg::status_t      s1_status;
  logic                   s1_closed;
  logic                   s1_rd;

  // output register
  logic                   out_valid;
  tbrf_pkg::status_t      out_status;
  logic [tbrf_pkg::PayloadWidth-1:0] out_data;
  logic                   out_closed;

  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !rst && (!s1_valid || s1_adv);
  assign take      = req.valid && req.ready;

  tbrf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .opcode  (tbrf_pkg::op_t'(req.opcode)),
    .ctrl    (ctrl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  tbrf_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.payload[DATA_WIDTH-1:0]),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage: waits for the store's registered data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_status <= ctrl.status;
      s1_closed <= ctrl.closed;
      s1_rd     <= ctrl.rd_en;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_status <= s1_status;
      out_closed <= s1_closed;
      out_data   <= s1_rd ? tbrf_pkg::PayloadWidth'(rd_data) : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_data   = out_data;
  assign rsp.closed_flag = out_closed;

  // A single operation never both writes and reads the store.
  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.wr_en, ctrl.rd_en}))
    else $error("store write and read issued for one transaction");

  // A result stuck behind a stalled output stays in the read stage.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("pending result dropped from read stage");

  // Once reported closed, later results stay closed.
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.closed_flag |=> !rsp.valid || rsp.closed_flag)
    else $error("closed flag fell");

  // A store read or write is only issued for an accepted transaction.
  a_rd_on_take: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en || ctrl.wr_en |-> take)
    else $error("store access without accepted transaction");

endmodule

`default_nettype wire
